/* hw/rtl/assert_macros.svh */
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define AST_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/vhc_pkg.sv */
// ----------------------------------------------------------------------------
// vhc_pkg
// shared types, constants and helpers of the vocabulary hash counter
// ----------------------------------------------------------------------------
package vhc_pkg;

  localparam int SLOT_W     = 16;
  localparam int HASH_SLOTS = 1 << SLOT_W;
  localparam int ENTRY_W    = 15;
  localparam int VOCAB_ENTRIES = 1 << ENTRY_W;
  localparam int MAX_KEY    = 99;
  localparam int POS_W      = 7;
  localparam int KEY_ADDR_W = ENTRY_W + POS_W;
  localparam int USED_W     = 16;
  localparam int CNT_W      = 32;
  localparam int LIMIT_W    = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(VOCAB_ENTRIES);
  localparam logic [2:0] REG_ENTRY_LIMIT = 3'd0;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SLOT_RD, S_SLOT_CHK, S_LEN_CHK,
    S_CMP_RD, S_CMP_CHK, S_COPY_RD, S_COPY_WR
  } state_t;

  typedef struct packed {
    logic    byte_load;
    logic    clr_we;
    logic    slot_rd;
    logic    klen_rd;
    logic    probe_next;
    logic    pos_clr;
    logic    pos_inc;
    logic    cmp_rd;
    logic    copy_rd;
    logic    copy_wr;
    logic    ins_commit;
    logic    cnt_commit;
    logic    res_load;
    status_t res_status;
  } vhc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic slot_valid;
    logic len_eq;
    logic byte_eq;
    logic pos_last;
    logic probes_last;
    logic full;
    logic lookup;
  } vhc_stat_t;

  // one step of hash*257 + sign-extended byte, kept to the slot bits
  function automatic logic [SLOT_W-1:0] fold_byte(input logic [SLOT_W-1:0] h,
                                                   input logic [7:0] b);
    logic [SLOT_W-1:0] ext;
    ext = {{(SLOT_W-8){b[7]}}, b};
    return h + (h << 8) + ext;
  endfunction

endpackage

/* hw/rtl/vhc_ram.sv */
// ----------------------------------------------------------------------------
// vhc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module vhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/vhc_ctrl.sv */
// ----------------------------------------------------------------------------
// vhc_ctrl
// controller: slot clearing, probe sequencing, key compare and insert copy
// ----------------------------------------------------------------------------
module vhc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              last_byte,
  input  vhc_pkg::vhc_stat_t stat,
  output vhc_pkg::vhc_cmd_t  cmd,
  output logic              busy
);
  import vhc_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_status = ST_NOT_FOUND;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.byte_load = 1'b1;
          if (last_byte) begin
            state_nxt = S_SLOT_RD;
          end
        end
      end
      S_SLOT_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        if (!stat.slot_valid) begin
          if (stat.lookup) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            state_nxt      = S_IDLE;
          end else if (stat.full) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_FULL;
            state_nxt      = S_IDLE;
          end else begin
            cmd.pos_clr = 1'b1;
            state_nxt   = S_COPY_RD;
          end
        end else begin
          cmd.klen_rd = 1'b1;
          state_nxt   = S_LEN_CHK;
        end
      end
      S_LEN_CHK: begin
        if (stat.len_eq) begin
          cmd.pos_clr = 1'b1;
          state_nxt   = S_CMP_RD;
        end else if (stat.probes_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = stat.lookup ? ST_NOT_FOUND : ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_SLOT_RD;
        end
      end
      S_CMP_RD: begin
        cmd.cmp_rd = 1'b1;
        state_nxt  = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (!stat.byte_eq) begin
          if (stat.probes_last) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = stat.lookup ? ST_NOT_FOUND : ST_FULL;
            state_nxt      = S_IDLE;
          end else begin
            cmd.probe_next = 1'b1;
            state_nxt      = S_SLOT_RD;
          end
        end else if (stat.pos_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_FOUND;
          cmd.cnt_commit = !stat.lookup;
          state_nxt      = S_IDLE;
        end else begin
          cmd.pos_inc = 1'b1;
          state_nxt   = S_CMP_RD;
        end
      end
      S_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (stat.pos_last) begin
          cmd.ins_commit = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_INSERTED;
          state_nxt      = S_IDLE;
        end else begin
          cmd.pos_inc = 1'b1;
          state_nxt   = S_COPY_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* hw/rtl/vhc_dp.sv */
// ----------------------------------------------------------------------------
// vhc_dp
// datapath: word buffer, hash, slot table, key store, lengths and counts
// ----------------------------------------------------------------------------
module vhc_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vhc_pkg::vhc_cmd_t            cmd,
  input  logic [7:0]                   key_byte,
  input  logic                         last_byte,
  input  logic                         opcode,
  input  logic [vhc_pkg::LIMIT_W-1:0]  entry_limit,
  output vhc_pkg::vhc_stat_t           stat,
  output logic                         res_valid,
  output logic [vhc_pkg::ENTRY_W-1:0]  res_index,
  output logic [1:0]                   res_status,
  output logic [vhc_pkg::CNT_W-1:0]    res_count
);
  import vhc_pkg::*;

  logic [POS_W-1:0]   len_r;
  logic [SLOT_W-1:0]  hash_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  probes_r;
  logic [SLOT_W-1:0]  clr_r;
  logic               lookup_r;
  logic [ENTRY_W-1:0] entry_r;
  logic [POS_W-1:0]   pos_r;
  logic [USED_W-1:0]  used_r;
  logic               res_valid_r;
  logic [ENTRY_W-1:0] res_index_r;
  logic [1:0]         res_status_r;
  logic [CNT_W-1:0]   res_count_r;

  logic [SLOT_W-1:0]  hfold;
  logic [POS_W-1:0]   buf_waddr;
  logic [SLOT_W-1:0]  slot_addr;
  logic               slot_we;
  logic [SLOT_W-1:0]  slot_wdata;
  logic [SLOT_W-1:0]  slot_rdata;
  logic [POS_W-1:0]   klen_rdata;
  logic [CNT_W-1:0]   cnt_rdata;
  logic [CNT_W-1:0]   cnt_sat;
  logic [ENTRY_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [7:0]         buf_rdata;
  logic [7:0]         key_rdata;
  logic [USED_W-1:0]  limit_eff;

  assign hfold     = fold_byte(hash_r, key_byte);
  assign buf_waddr = (len_r < POS_W'(MAX_KEY)) ? len_r : POS_W'(MAX_KEY - 1);
  assign limit_eff = (entry_limit > LIMIT_W'(VOCAB_ENTRIES)) ?
                     USED_W'(VOCAB_ENTRIES) : USED_W'(entry_limit);
  assign cnt_sat   = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + CNT_W'(1);

  // word length, hash, clearing address and used-entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      hash_r <= '0;
      clr_r  <= '0;
      used_r <= '0;
    end else begin
      if (cmd.clr_we) begin
        clr_r <= clr_r + SLOT_W'(1);
      end
      if (cmd.byte_load) begin
        if (len_r < POS_W'(MAX_KEY)) begin
          len_r <= len_r + POS_W'(1);
        end
        if (last_byte) begin
          hash_r <= '0;
        end else if (len_r < POS_W'(MAX_KEY - 1)) begin
          hash_r <= hfold;
        end
      end
      if (cmd.res_load) begin
        len_r <= '0;
      end
      if (cmd.ins_commit) begin
        used_r <= used_r + USED_W'(1);
      end
    end
  end

  // probe position, entry and byte position
  always_ff @(posedge clk) begin
    if (cmd.byte_load && last_byte) begin
      slot_r   <= hfold;
      probes_r <= '0;
      lookup_r <= opcode;
    end
    if (cmd.probe_next) begin
      slot_r   <= slot_r + SLOT_W'(1);
      probes_r <= probes_r + SLOT_W'(1);
    end
    if (cmd.klen_rd) begin
      entry_r <= slot_rdata[ENTRY_W-1:0];
    end
    if (cmd.pos_clr) begin
      pos_r <= '0;
    end else if (cmd.pos_inc) begin
      pos_r <= pos_r + POS_W'(1);
    end
  end

  // word buffer
  vhc_ram #(.WIDTH(8), .DEPTH(MAX_KEY)) u_buf (
    .clk   (clk),
    .we    (cmd.byte_load),
    .waddr (buf_waddr),
    .wdata (key_byte),
    .re    (cmd.cmp_rd || cmd.copy_rd),
    .raddr (pos_r),
    .rdata (buf_rdata)
  );

  // slot table: valid bit over entry number
  assign slot_addr  = cmd.clr_we ? clr_r : slot_r;
  assign slot_we    = cmd.clr_we || cmd.ins_commit;
  assign slot_wdata = cmd.clr_we ? '0 : {1'b1, used_r[ENTRY_W-1:0]};

  vhc_ram #(.WIDTH(SLOT_W), .DEPTH(HASH_SLOTS)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_addr),
    .wdata (slot_wdata),
    .re    (cmd.slot_rd),
    .raddr (slot_r),
    .rdata (slot_rdata)
  );

  // key store, one row of bytes per entry
  vhc_ram #(.WIDTH(8), .DEPTH(1 << KEY_ADDR_W)) u_key (
    .clk   (clk),
    .we    (cmd.copy_wr),
    .waddr ({used_r[ENTRY_W-1:0], pos_r}),
    .wdata (buf_rdata),
    .re    (cmd.cmp_rd),
    .raddr ({entry_r, pos_r}),
    .rdata (key_rdata)
  );

  // key lengths
  vhc_ram #(.WIDTH(POS_W), .DEPTH(VOCAB_ENTRIES)) u_klen (
    .clk   (clk),
    .we    (cmd.ins_commit),
    .waddr (used_r[ENTRY_W-1:0]),
    .wdata (len_r),
    .re    (cmd.klen_rd),
    .raddr (slot_rdata[ENTRY_W-1:0]),
    .rdata (klen_rdata)
  );

  // occurrence counts
  assign cnt_waddr = cmd.ins_commit ? used_r[ENTRY_W-1:0] : entry_r;
  assign cnt_wdata = cmd.ins_commit ? CNT_W'(1) : cnt_sat;

  vhc_ram #(.WIDTH(CNT_W), .DEPTH(VOCAB_ENTRIES)) u_cnt (
    .clk   (clk),
    .we    (cmd.ins_commit || cmd.cnt_commit),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.klen_rd),
    .raddr (slot_rdata[ENTRY_W-1:0]),
    .rdata (cnt_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      case (cmd.res_status)
        ST_FOUND: begin
          res_index_r <= entry_r;
          res_count_r <= lookup_r ? cnt_rdata : cnt_sat;
        end
        ST_INSERTED: begin
          res_index_r <= used_r[ENTRY_W-1:0];
          res_count_r <= CNT_W'(1);
        end
        default: begin
          res_index_r <= '0;
          res_count_r <= '0;
        end
      endcase
    end
  end

  // status to the controller
  assign stat.clr_last    = (clr_r == '1);
  assign stat.slot_valid  = slot_rdata[SLOT_W-1];
  assign stat.len_eq      = (klen_rdata == len_r);
  assign stat.byte_eq     = (key_rdata == buf_rdata);
  assign stat.pos_last    = ((pos_r + POS_W'(1)) == len_r);
  assign stat.probes_last = (probes_r == '1);
  assign stat.full        = (used_r >= limit_eff);
  assign stat.lookup      = lookup_r;

  assign res_valid  = res_valid_r;
  assign res_index  = res_index_r;
  assign res_status = res_status_r;
  assign res_count  = res_count_r;

endmodule

/* hw/rtl/vocabulary_hash_counter_unit.sv */
// ----------------------------------------------------------------------------
// vocabulary_hash_counter_unit
// word-count vocabulary on a linear-probing hash table, one key byte per request
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     in_key_byte, in_last_byte, in_opcode    start && !busy
//  result    out_entry_index, out_status,            out_valid, one cycle
//            out_occurrence_count
//  config    psel, penable, pwrite, paddr, pwdata    apb, pready always high
//
//  a byte that is not the last of its word is taken without raising busy
//  a last byte then holds busy for a slot read and check per slot probed, a
//  length check per occupied slot, a read and check per compared key byte and
//  a read and write per byte copied on insert, paced by the registered reads
//  after reset a clearing pass over all 65536 slot table entries holds busy high
//  the result strobe comes in the first idle cycle and cannot be stalled
module vocabulary_hash_counter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [7:0]                  in_key_byte,
  input  logic                        in_last_byte,
  input  logic                        in_opcode,
  output logic                        out_valid,
  output logic [vhc_pkg::ENTRY_W-1:0] out_entry_index,
  output logic [1:0]                  out_status,
  output logic [vhc_pkg::CNT_W-1:0]   out_occurrence_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import vhc_pkg::*;

  vhc_cmd_t            cmd;
  vhc_stat_t           stat;
  logic [LIMIT_W-1:0]  entry_limit_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == 3'(4 * REG_ENTRY_LIMIT)) begin
      entry_limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 3'(4 * REG_ENTRY_LIMIT)) ?
                  {{(32-LIMIT_W){1'b0}}, entry_limit_r} : '0;

  vhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_byte (in_last_byte),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  vhc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .key_byte    (in_key_byte),
    .last_byte   (in_last_byte),
    .opcode      (in_opcode),
    .entry_limit (entry_limit_r),
    .stat        (stat),
    .res_valid   (out_valid),
    .res_index   (out_entry_index),
    .res_status  (out_status),
    .res_count   (out_occurrence_count)
  );

endmodule

/* hw/rtl/vhc_checker.sv */
// ----------------------------------------------------------------------------
// vhc_checker
// port-level checks on the vocabulary hash counter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vhc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_last_byte,
  input logic                        out_valid,
  input logic [vhc_pkg::ENTRY_W-1:0] out_entry_index,
  input logic [1:0]                  out_status,
  input logic [vhc_pkg::CNT_W-1:0]   out_occurrence_count
);
  import vhc_pkg::*;

  // a last byte always starts a search
  `AST_NEXT(a_last_busy, clk, rst_n, start && !busy && in_last_byte, busy)
  // results come one at a time, back in idle
  `AST_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `AST_NOW(a_result_idle, clk, rst_n, out_valid, !busy)
  // misses report entry 0 and count 0
  `AST_NOW(a_miss_zero, clk, rst_n, out_valid && (out_status == ST_NOT_FOUND || out_status == ST_FULL), out_entry_index == '0 && out_occurrence_count == '0)
  // fresh inserts start at one
  `AST_NOW(a_insert_one, clk, rst_n, out_valid && out_status == ST_INSERTED, out_occurrence_count == 32'd1)

endmodule

bind vocabulary_hash_counter_unit vhc_checker u_vhc_checker (.*);

/* tb/sv/vhc_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vhc_result_checker
// watches the byte requests, register writes and result strobes of the
// vocabulary hash counter, predicts each word's result from its own copy
// of the hash table and compares the fields in order
// ----------------------------------------------------------------------------
module vhc_result_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [7:0]                  in_key_byte,
  input  logic                        in_last_byte,
  input  logic                        in_opcode,
  input  logic                        out_valid,
  input  logic [vhc_pkg::ENTRY_W-1:0] out_entry_index,
  input  logic [1:0]                  out_status,
  input  logic [vhc_pkg::CNT_W-1:0]   out_occurrence_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output int                          fail_count,
  output int                          pending
);
  import vhc_pkg::*;

  typedef struct {
    logic [ENTRY_W-1:0] index;
    status_t            status;
    logic [CNT_W-1:0]   count;
  } word_result_t;

  typedef logic [7:0] key_bytes_t[$];

  word_result_t       expected_words[$];
  logic [63:0]        word_hash;
  int                 kept_len;
  logic [7:0]         word_bytes[MAX_KEY];
  bit                 slot_taken[HASH_SLOTS];
  int                 slot_entry[HASH_SLOTS];
  key_bytes_t         entry_key[int];
  logic [CNT_W-1:0]   entry_count[int];
  int                 entries_used;
  logic [LIMIT_W-1:0] limit_reg;

  function automatic logic [63:0] hash_step(input logic [63:0] h, input logic [7:0] b);
    return h * 64'd257 + {{56{b[7]}}, b};
  endfunction

  function automatic bit key_equal(input int e);
    if (entry_key[e].size() != kept_len) return 0;
    for (int i = 0; i < kept_len; i++)
      if (entry_key[e][i] !== word_bytes[i]) return 0;
    return 1;
  endfunction

  // probe the table for the word just ended and update the vocabulary
  function automatic word_result_t lookup_word(input bit lookup_only);
    word_result_t r;
    logic [63:0]  h;
    int           slot;
    int           cap;
    key_bytes_t   kept;
    bit           done;
    r.index = '0;
    r.status = lookup_only ? ST_NOT_FOUND : ST_FULL;
    r.count = '0;
    done = 0;
    h = word_hash;
    if (kept_len == MAX_KEY) h = hash_step(h, word_bytes[MAX_KEY-1]);
    slot = int'(h[SLOT_W-1:0]);
    cap = (limit_reg > VOCAB_ENTRIES) ? VOCAB_ENTRIES : int'(limit_reg);
    for (int p = 0; p < HASH_SLOTS && !done; p++) begin
      if (!slot_taken[slot]) begin
        done = 1;
        if (lookup_only) begin
          r.status = ST_NOT_FOUND;
        end else if (entries_used >= cap) begin
          r.status = ST_FULL;
        end else begin
          kept = {};
          for (int i = 0; i < kept_len; i++) kept.push_back(word_bytes[i]);
          entry_key[entries_used] = kept;
          entry_count[entries_used] = 1;
          slot_taken[slot] = 1;
          slot_entry[slot] = entries_used;
          r.index = ENTRY_W'(entries_used);
          r.count = 1;
          r.status = ST_INSERTED;
          entries_used++;
        end
      end else if (key_equal(slot_entry[slot])) begin
        done = 1;
        if (!lookup_only && entry_count[slot_entry[slot]] != '1)
          entry_count[slot_entry[slot]]++;
        r.index = ENTRY_W'(slot_entry[slot]);
        r.count = entry_count[slot_entry[slot]];
        r.status = ST_FOUND;
      end else begin
        slot = (slot + 1) % HASH_SLOTS;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    word_hash = '0;
    kept_len = 0;
    entries_used = 0;
    limit_reg = LIMIT_RESET;
  end

  always @(posedge clk) begin
    word_result_t w;
    if (rst_n) begin
      // compare a result strobe with the oldest word
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(out_status), 32'hx);
        end else begin
          w = expected_words.pop_front();
          pending = expected_words.size();
          if (out_entry_index !== w.index)
            report_mismatch("entry_index", 32'(out_entry_index), 32'(w.index));
          if (out_status !== w.status)
            report_mismatch("status", 32'(out_status), 32'(w.status));
          if (out_occurrence_count !== w.count)
            report_mismatch("occurrence_count", out_occurrence_count, w.count);
        end
      end
      // register write
      if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_ENTRY_LIMIT))
        limit_reg = pwdata[LIMIT_W-1:0];
      // accepted byte request
      if (start && !busy) begin
        if (kept_len < MAX_KEY) begin
          word_bytes[kept_len] = in_key_byte;
          if (kept_len < MAX_KEY - 1) word_hash = hash_step(word_hash, in_key_byte);
          kept_len++;
        end else begin
          word_bytes[MAX_KEY-1] = in_key_byte;
        end
        if (in_last_byte) begin
          expected_words.push_back(lookup_word(in_opcode));
          pending = expected_words.size();
          kept_len = 0;
          word_hash = '0;
        end
      end
    end
  end

endmodule

/* tb/sv/tb_vocabulary_hash_counter_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vocabulary_hash_counter_unit
// drives words byte by byte with random gaps, counts and looks them up over
// several entry limits, and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_vocabulary_hash_counter_unit;
  import vhc_pkg::*;

  typedef logic [7:0] word_t[$];

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [7:0]          in_key_byte;
  logic                in_last_byte;
  logic                in_opcode;
  logic                out_valid;
  logic [ENTRY_W-1:0]  out_entry_index;
  logic [1:0]          out_status;
  logic [CNT_W-1:0]    out_occurrence_count;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count;
  int                  pending;
  int                  byte_requests;
  word_t               vocab_pool[$];
  bit                  gaps_on;

  vocabulary_hash_counter_unit dut (.*);

  vhc_result_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // send one word, one byte request per byte; start is already low on entry,
  // so the first byte is always held back by a gap, which the search after the
  // previous word's last byte covers anyway
  task automatic send_word(input word_t w, input bit lookup_only);
    int gap;
    for (int i = 0; i < w.size(); i++) begin
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (i == 0 && gap == 0) gap = 1;
      if (gap > 0) begin
        if (i > 0) start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      start <= 1'b1;
      in_key_byte <= w[i];
      in_last_byte <= (i == w.size() - 1);
      in_opcode <= lookup_only;
      @(negedge clk);
      while (busy) @(negedge clk);
      @(posedge clk);
      byte_requests++;
    end
    start <= 1'b0;
  endtask

  // register write once every word result has come back
  task automatic write_limit(input logic [31:0] value);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_ENTRY_LIMIT);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic word_t random_word(input int len);
    word_t w;
    for (int i = 0; i < len; i++) w.push_back(8'($urandom));
    return w;
  endfunction

  // mostly pooled words so counts climb, some fresh words and long keys
  task automatic random_phase(input int n_bytes);
    word_t w;
    int    stop_at;
    stop_at = byte_requests + n_bytes;
    while (byte_requests < stop_at) begin
      case ($urandom_range(0, 9))
        0: w = random_word($urandom_range(1, 12));
        1: begin
          w = vocab_pool[$urandom_range(0, vocab_pool.size() - 1)];
          if ($urandom_range(0, 3) == 0) w = random_word($urandom_range(97, 130));
        end
        default: w = vocab_pool[$urandom_range(0, vocab_pool.size() - 1)];
      endcase
      if ($urandom_range(0, 40) == 0) gaps_on = !gaps_on;
      send_word(w, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    word_t w;
    word_t long_a;
    word_t long_b;
    start = 1'b0;
    in_key_byte = '0;
    in_last_byte = 1'b0;
    in_opcode = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_requests = 0;
    gaps_on = 1'b1;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, colliding keys with leading zero bytes
    send_word('{8'h00}, 1'b1);
    send_word('{8'h00}, 1'b0);
    send_word('{8'hff}, 1'b0);
    send_word('{8'h80}, 1'b0);
    send_word('{8'h7f}, 1'b0);
    send_word('{8'h00, 8'h80}, 1'b0);
    send_word('{8'h00, 8'h00, 8'h80}, 1'b0);
    send_word('{8'h00, 8'h80}, 1'b0);
    send_word('{8'h80}, 1'b1);
    send_word('{8'h00, 8'h00, 8'h80}, 1'b1);
    send_word('{8'h55, 8'haa}, 1'b1);

    for (int i = 0; i < 40; i++) vocab_pool.push_back(random_word($urandom_range(1, 8)));
    // long keys: same first 98 bytes and last byte, different middle
    long_a = random_word(110);
    long_b = long_a;
    for (int i = 98; i < 109; i++) long_b[i] = ~long_a[i];
    vocab_pool.push_back(long_a);
    vocab_pool.push_back(long_b);
    vocab_pool.push_back(random_word(99));
    vocab_pool.push_back(random_word(98));

    random_phase(700);
    write_limit(32'd1);
    random_phase(150);
    write_limit(32'd0);
    random_phase(150);
    write_limit(32'hffff);
    random_phase(400);
    write_limit(32'd40);
    random_phase(200);
    write_limit(32'd32768);
    random_phase(250);

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/vhc_pkg.sv
hw/rtl/vhc_ram.sv
hw/rtl/vhc_ctrl.sv
hw/rtl/vhc_dp.sv
hw/rtl/vocabulary_hash_counter_unit.sv
hw/rtl/vhc_checker.sv
tb/sv/vhc_result_checker.sv
tb/sv/tb_vocabulary_hash_counter_unit.sv
